// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL; clocked on clk, masked while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define PPP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds at a rising edge outside reset.
`define PPP_ASSERT_NEVER(lbl, cond, msg) \
	`PPP_ASSERT(lbl, !(cond), msg)

`endif

// File: hdl/ppp_pkg.sv
package ppp_pkg;

	// Image geometry
	localparam int IMAGE_WIDTH  = 256;
	localparam int IMAGE_HEIGHT = 256;
	localparam int NPIX         = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int ADDR_W       = $clog2(NPIX);

	// Field widths
	localparam int COORD_W = 16;
	localparam int COLOR_W = 8;
	localparam int PIX_W   = 3 * COLOR_W;
	localparam int COUNT_W = 17;
	localparam int RSUM_W  = 24;
	localparam int MEAN_W  = 16;

	// Running statistics and divider widths
	localparam int CNT_W  = $clog2(NPIX + 1);
	localparam int SUM_W  = CNT_W + COLOR_W;
	localparam int DIV_W  = SUM_W + 8;
	localparam int STEP_W = $clog2(DIV_W + 1);

	// Saturation limits of the reported fields
	localparam longint COUNT_MAX = (64'd1 << COUNT_W) - 1;
	localparam longint RSUM_MAX  = (64'd1 << RSUM_W) - 1;
	localparam longint MEAN_MAX  = (64'd1 << MEAN_W) - 1;

	// Drawable window, centred on the image
	localparam logic signed [COORD_W-1:0] MAX_X  = COORD_W'(IMAGE_WIDTH / 2 - 1);
	localparam logic signed [COORD_W-1:0] MIN_X  = COORD_W'(-(IMAGE_WIDTH / 2 - 1));
	localparam logic signed [COORD_W-1:0] MAX_Y  = COORD_W'(IMAGE_HEIGHT / 2 - 1);
	localparam logic signed [COORD_W-1:0] MIN_Y  = COORD_W'(-(IMAGE_HEIGHT / 2 - 1));
	localparam logic [COORD_W-1:0]        HALF_X = COORD_W'(IMAGE_WIDTH / 2);
	localparam logic [COORD_W-1:0]        HALF_Y = COORD_W'(IMAGE_HEIGHT / 2);

	// Pixel after clear: red 0, green 0, blue 255
	localparam logic [PIX_W-1:0] CLEAR_PIXEL = PIX_W'(255);

	// Operation codes
	localparam logic [1:0] MODE_PLOT  = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_STATS = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PLOT,
		ST_DIV,
		ST_CLEAR
	} state_t;

endpackage

// File: hdl/ppp_ram.sv
module ppp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/priority_pixel_plotter.sv
// Channel | Handshake           | Payload
// input   | in_valid / in_ready | mode, coord_x, coord_y, red_in, green_in, blue_in
// output  | out_valid/out_ready | in_range, written, pixel_count, red_sum, mean_red, mean_valid
//
// Plot: a read of the frame RAM on accept, then the compare and write back in ST_PLOT.
// Statistics: one quotient bit per cycle in the divider.
// Clear: one RAM entry written per cycle, the last one held while the output register is occupied.
// After reset the same pass runs over all NPIX (65536) entries with in_ready low.
// A result waits in the output register; the next transaction is taken meanwhile, and an
// item holds its last cycle while the output register is still occupied.
`include "assert_macros.svh"

module priority_pixel_plotter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           mode,
	input  logic signed [ppp_pkg::COORD_W-1:0]   coord_x,
	input  logic signed [ppp_pkg::COORD_W-1:0]   coord_y,
	input  logic [ppp_pkg::COLOR_W-1:0]          red_in,
	input  logic [ppp_pkg::COLOR_W-1:0]          green_in,
	input  logic [ppp_pkg::COLOR_W-1:0]          blue_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 in_range,
	output logic                                 written,
	output logic [ppp_pkg::COUNT_W-1:0]          pixel_count,
	output logic [ppp_pkg::RSUM_W-1:0]           red_sum,
	output logic [ppp_pkg::MEAN_W-1:0]           mean_red,
	output logic                                 mean_valid
);

	ppp_pkg::state_t state_q, state_d;

	logic [ppp_pkg::ADDR_W-1:0]  clr_addr_q;
	logic                        clr_reply_q;
	logic                        clr_last;
	logic [ppp_pkg::CNT_W-1:0]   run_cnt_q;
	logic [ppp_pkg::SUM_W-1:0]   run_sum_q;

	logic                        hit_q;
	logic [ppp_pkg::ADDR_W-1:0]  pidx_q;
	logic [ppp_pkg::COLOR_W-1:0] red_q, green_q, blue_q;

	logic [ppp_pkg::DIV_W-1:0]   quot_q;
	logic [ppp_pkg::CNT_W-1:0]   rem_q;
	logic [ppp_pkg::STEP_W-1:0]  step_q;
	logic [ppp_pkg::CNT_W:0]     trial;
	logic [ppp_pkg::CNT_W:0]     diff;
	logic                        q_bit;
	logic                        div_done;

	logic                        out_valid_q;
	logic                        in_range_q, written_q, mean_valid_q;
	logic [ppp_pkg::COUNT_W-1:0] count_q;
	logic [ppp_pkg::RSUM_W-1:0]  rsum_q;
	logic [ppp_pkg::MEAN_W-1:0]  mean_q;

	logic                        accept;
	logic                        done_ok;
	logic                        win_ok;
	logic [ppp_pkg::COORD_W-1:0] x_off, y_off;
	logic [ppp_pkg::ADDR_W-1:0]  plot_idx;
	logic [ppp_pkg::COLOR_W-1:0] old_red;

	logic                        ram_we, ram_re;
	logic [ppp_pkg::ADDR_W-1:0]  ram_waddr;
	logic [ppp_pkg::PIX_W-1:0]   ram_wdata, ram_rdata;

	logic                        out_load;
	logic                        res_in_range, res_written, res_mean_valid;
	logic [ppp_pkg::COUNT_W-1:0] res_count;
	logic [ppp_pkg::RSUM_W-1:0]  res_rsum;
	logic [ppp_pkg::MEAN_W-1:0]  res_mean;

	// Handshake
	assign in_ready = (state_q == ppp_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign done_ok  = !out_valid_q || out_ready;

	// Window check and frame address of a plot
	assign win_ok = (coord_x >= ppp_pkg::MIN_X) && (coord_x <= ppp_pkg::MAX_X)
		&& (coord_y >= ppp_pkg::MIN_Y) && (coord_y <= ppp_pkg::MAX_Y);
	assign x_off = $unsigned(coord_x) + ppp_pkg::HALF_X;
	assign y_off = $unsigned(coord_y) + ppp_pkg::HALF_Y;
	assign plot_idx = ppp_pkg::ADDR_W'(ppp_pkg::ADDR_W'(y_off)
		* ppp_pkg::ADDR_W'(ppp_pkg::IMAGE_WIDTH) + ppp_pkg::ADDR_W'(x_off));

	// Priority: a smaller red wins and a tie keeps the stored pixel; an empty pixel takes any write
	assign old_red = ram_rdata[ppp_pkg::PIX_W-1 -: ppp_pkg::COLOR_W];
	assign ram_re  = accept && (mode == ppp_pkg::MODE_PLOT);

	// Divider step: restoring, one quotient bit per cycle
	assign trial    = {rem_q, quot_q[ppp_pkg::DIV_W-1]};
	assign q_bit    = (trial >= {1'b0, run_cnt_q});
	assign diff     = trial - {1'b0, run_cnt_q};
	assign div_done = (step_q == ppp_pkg::STEP_W'(ppp_pkg::DIV_W));

	assign clr_last = (clr_addr_q == ppp_pkg::ADDR_W'(ppp_pkg::NPIX - 1));

	ppp_ram #(
		.WIDTH (ppp_pkg::PIX_W),
		.DEPTH (ppp_pkg::NPIX)
	) u_frame_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (plot_idx),
		.rdata (ram_rdata)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppp_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state, RAM write and result selection
	always_comb begin
		state_d        = state_q;
		out_load       = 1'b0;
		ram_we         = 1'b0;
		ram_waddr      = pidx_q;
		ram_wdata      = {red_q, green_q, blue_q};
		res_in_range   = 1'b0;
		res_written    = 1'b0;
		res_count      = '0;
		res_rsum       = '0;
		res_mean       = '0;
		res_mean_valid = 1'b0;
		case (state_q)
			ppp_pkg::ST_IDLE: begin
				if (accept) begin
					case (mode)
						ppp_pkg::MODE_CLEAR: state_d = ppp_pkg::ST_CLEAR;
						ppp_pkg::MODE_STATS: state_d = ppp_pkg::ST_DIV;
						default:             state_d = ppp_pkg::ST_PLOT;
					endcase
				end
			end
			ppp_pkg::ST_PLOT: begin
				res_in_range = hit_q;
				res_written  = hit_q && ((old_red == '0) || (old_red > red_q));
				if (done_ok) begin
					out_load = 1'b1;
					ram_we   = res_written;
					state_d  = ppp_pkg::ST_IDLE;
				end
			end
			ppp_pkg::ST_DIV: begin
				res_count = (64'(run_cnt_q) > ppp_pkg::COUNT_MAX) ?
					ppp_pkg::COUNT_W'(ppp_pkg::COUNT_MAX) : ppp_pkg::COUNT_W'(run_cnt_q);
				res_rsum = (64'(run_sum_q) > ppp_pkg::RSUM_MAX) ?
					ppp_pkg::RSUM_W'(ppp_pkg::RSUM_MAX) : ppp_pkg::RSUM_W'(run_sum_q);
				res_mean_valid = (run_cnt_q != '0);
				if (res_mean_valid) begin
					res_mean = (64'(quot_q) > ppp_pkg::MEAN_MAX) ?
						ppp_pkg::MEAN_W'(ppp_pkg::MEAN_MAX) : ppp_pkg::MEAN_W'(quot_q);
				end
				if (div_done && done_ok) begin
					out_load = 1'b1;
					state_d  = ppp_pkg::ST_IDLE;
				end
			end
			ppp_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_addr_q;
				ram_wdata = ppp_pkg::CLEAR_PIXEL;
				if (clr_last && (!clr_reply_q || done_ok)) begin
					out_load = clr_reply_q;
					state_d  = ppp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ppp_pkg::ST_IDLE;
			end
		endcase
	end

	// Clear sweep, running statistics and divider control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q  <= '0;
			clr_reply_q <= 1'b0;
			run_cnt_q   <= '0;
			run_sum_q   <= '0;
			step_q      <= '0;
		end else begin
			if (accept && (mode == ppp_pkg::MODE_CLEAR)) begin
				clr_addr_q  <= '0;
				clr_reply_q <= 1'b1;
				run_cnt_q   <= '0;
				run_sum_q   <= '0;
			end else if ((state_q == ppp_pkg::ST_CLEAR) && !clr_last) begin
				clr_addr_q <= clr_addr_q + ppp_pkg::ADDR_W'(1);
			end
			if ((state_q == ppp_pkg::ST_PLOT) && ram_we) begin
				run_sum_q <= run_sum_q - ppp_pkg::SUM_W'(old_red) + ppp_pkg::SUM_W'(red_q);
				run_cnt_q <= run_cnt_q - ppp_pkg::CNT_W'(old_red != '0)
					+ ppp_pkg::CNT_W'(red_q != '0);
			end
			if (accept && (mode == ppp_pkg::MODE_STATS)) begin
				step_q <= '0;
			end else if ((state_q == ppp_pkg::ST_DIV) && !div_done) begin
				step_q <= step_q + ppp_pkg::STEP_W'(1);
			end
		end
	end

	// Plot operands and divider datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q   <= (mode == ppp_pkg::MODE_PLOT) && win_ok;
			pidx_q  <= plot_idx;
			red_q   <= red_in;
			green_q <= green_in;
			blue_q  <= blue_in;
		end
		if (accept && (mode == ppp_pkg::MODE_STATS)) begin
			quot_q <= {run_sum_q, 8'b0};
			rem_q  <= '0;
		end else if ((state_q == ppp_pkg::ST_DIV) && !div_done) begin
			rem_q  <= q_bit ? diff[ppp_pkg::CNT_W-1:0] : trial[ppp_pkg::CNT_W-1:0];
			quot_q <= {quot_q[ppp_pkg::DIV_W-2:0], q_bit};
		end
	end

	// Output register valid: load wins over drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			in_range_q   <= res_in_range;
			written_q    <= res_written;
			count_q      <= res_count;
			rsum_q       <= res_rsum;
			mean_q       <= res_mean;
			mean_valid_q <= res_mean_valid;
		end
	end

	assign out_valid   = out_valid_q;
	assign in_range    = in_range_q;
	assign written     = written_q;
	assign pixel_count = count_q;
	assign red_sum     = rsum_q;
	assign mean_red    = mean_q;
	assign mean_valid  = mean_valid_q;

	`PPP_ASSERT(a_empty_sum_zero, (run_cnt_q == '0) |-> (run_sum_q == '0), "sum without pixels")
	`PPP_ASSERT_NEVER(a_written_out_of_range, out_valid_q && written_q && !in_range_q, "write outside window")
	`PPP_ASSERT(a_plot_no_stats, (out_valid_q && in_range_q) |-> ((count_q == '0) && !mean_valid_q), "plot result carries statistics")
	`PPP_ASSERT(a_mean_bound, (out_valid_q && mean_valid_q) |-> (mean_q <= 16'hFF00), "mean above largest red")

endmodule

// File: sim/frame_checker.sv
`timescale 1ns / 100ps

module frame_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [1:0]                         mode,
	input  logic signed [ppp_pkg::COORD_W-1:0] coord_x,
	input  logic signed [ppp_pkg::COORD_W-1:0] coord_y,
	input  logic [ppp_pkg::COLOR_W-1:0]        red_in,
	input  logic [ppp_pkg::COLOR_W-1:0]        green_in,
	input  logic [ppp_pkg::COLOR_W-1:0]        blue_in,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic                               in_range,
	input  logic                               written,
	input  logic [ppp_pkg::COUNT_W-1:0]        pixel_count,
	input  logic [ppp_pkg::RSUM_W-1:0]         red_sum,
	input  logic [ppp_pkg::MEAN_W-1:0]         mean_red,
	input  logic                               mean_valid,
	output int                                 mismatch_count,
	output int                                 replies_owed
);

	typedef struct packed {
		logic                        in_range;
		logic                        written;
		logic [ppp_pkg::COUNT_W-1:0] pixel_count;
		logic [ppp_pkg::RSUM_W-1:0]  red_sum;
		logic [ppp_pkg::MEAN_W-1:0]  mean_red;
		logic                        mean_valid;
	} frame_reply_t;

	// Shadow frame store with its running statistics
	logic [ppp_pkg::PIX_W-1:0] frame_mem [ppp_pkg::NPIX];
	int unsigned               lit_count;
	longint unsigned           red_total;

	frame_reply_t reply_queue [$];
	int           mismatches;

	// Reset every pixel to the cleared color and zero the statistics
	function automatic void frame_wipe();
		for (int i = 0; i < ppp_pkg::NPIX; i++) begin
			frame_mem[i] = ppp_pkg::CLEAR_PIXEL;
		end
		lit_count = 0;
		red_total = 0;
	endfunction

	// Apply one transaction to the shadow store and return the reply it causes
	function automatic frame_reply_t frame_apply(input logic [1:0] op,
			input logic signed [ppp_pkg::COORD_W-1:0] cx,
			input logic signed [ppp_pkg::COORD_W-1:0] cy,
			input logic [ppp_pkg::COLOR_W-1:0] r, input logic [ppp_pkg::COLOR_W-1:0] g,
			input logic [ppp_pkg::COLOR_W-1:0] b);
		frame_reply_t                rep;
		int unsigned                 idx;
		logic [ppp_pkg::COLOR_W-1:0] old_red;
		longint unsigned             mean;
		rep = '0;
		case (op)
			ppp_pkg::MODE_PLOT: begin
				if (cx >= ppp_pkg::MIN_X && cx <= ppp_pkg::MAX_X
						&& cy >= ppp_pkg::MIN_Y && cy <= ppp_pkg::MAX_Y) begin
					rep.in_range = 1'b1;
					idx = (int'(cy) + ppp_pkg::IMAGE_HEIGHT / 2) * ppp_pkg::IMAGE_WIDTH
						+ (int'(cx) + ppp_pkg::IMAGE_WIDTH / 2);
					old_red = frame_mem[idx][ppp_pkg::PIX_W-1 -: ppp_pkg::COLOR_W];
					// Smaller red wins, a tie keeps the old pixel; an empty pixel always takes the write
					if (old_red == '0 || old_red > r) begin
						if (old_red != '0) begin
							red_total -= 64'(old_red);
							lit_count--;
						end
						if (r != '0) begin
							red_total += 64'(r);
							lit_count++;
						end
						frame_mem[idx] = {r, g, b};
						rep.written = 1'b1;
					end
				end
			end
			ppp_pkg::MODE_CLEAR: begin
				frame_wipe();
			end
			ppp_pkg::MODE_STATS: begin
				rep.pixel_count = (64'(lit_count) > ppp_pkg::COUNT_MAX)
					? ppp_pkg::COUNT_W'(ppp_pkg::COUNT_MAX) : ppp_pkg::COUNT_W'(lit_count);
				rep.red_sum = (red_total > ppp_pkg::RSUM_MAX)
					? ppp_pkg::RSUM_W'(ppp_pkg::RSUM_MAX) : ppp_pkg::RSUM_W'(red_total);
				if (lit_count != 0) begin
					mean = (red_total << 8) / 64'(lit_count);
					rep.mean_red = (mean > ppp_pkg::MEAN_MAX)
						? ppp_pkg::MEAN_W'(ppp_pkg::MEAN_MAX) : ppp_pkg::MEAN_W'(mean);
					rep.mean_valid = 1'b1;
				end
			end
			default: begin
			end
		endcase
		return rep;
	endfunction

	function automatic void field_check(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Retire replies first, then queue the reply of any new transaction
	always @(posedge clk or negedge arst_n) begin
		frame_reply_t due;
		if (!arst_n) begin
			frame_wipe();
			reply_queue.delete();
			mismatches = 0;
		end else begin
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				if (reply_queue.size() == 0) begin
					$error("result transaction with no item awaiting it");
					mismatches++;
				end else begin
					due = reply_queue.pop_front();
					field_check("in_range", 32'(due.in_range), 32'(in_range));
					field_check("written", 32'(due.written), 32'(written));
					field_check("pixel_count", 32'(due.pixel_count), 32'(pixel_count));
					field_check("red_sum", 32'(due.red_sum), 32'(red_sum));
					field_check("mean_red", 32'(due.mean_red), 32'(mean_red));
					field_check("mean_valid", 32'(due.mean_valid), 32'(mean_valid));
				end
			end
			if (in_valid === 1'b1 && in_ready === 1'b1) begin
				reply_queue.push_back(frame_apply(mode, coord_x, coord_y,
					red_in, green_in, blue_in));
			end
		end
		mismatch_count <= mismatches;
		replies_owed <= reply_queue.size();
	end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam logic [1:0] MODE_UNUSED      = 2'd3;
	localparam int         QUIET_LIMIT      = 400000;
	localparam int         RANDOM_PER_PHASE = 333;
	localparam int         TAIL_CYCLES      = 40;

	logic                               clk       = 1'b0;
	logic                               arst_n    = 1'b0;
	logic                               in_valid  = 1'b0;
	logic                               in_ready;
	logic [1:0]                         mode      = ppp_pkg::MODE_PLOT;
	logic signed [ppp_pkg::COORD_W-1:0] coord_x   = '0;
	logic signed [ppp_pkg::COORD_W-1:0] coord_y   = '0;
	logic [ppp_pkg::COLOR_W-1:0]        red_in    = '0;
	logic [ppp_pkg::COLOR_W-1:0]        green_in  = '0;
	logic [ppp_pkg::COLOR_W-1:0]        blue_in   = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic                               in_range;
	logic                               written;
	logic [ppp_pkg::COUNT_W-1:0]        pixel_count;
	logic [ppp_pkg::RSUM_W-1:0]         red_sum;
	logic [ppp_pkg::MEAN_W-1:0]         mean_red;
	logic                               mean_valid;
	int                                 mismatch_count;
	int                                 replies_owed;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int quiet_cycles   = 0;

	priority_pixel_plotter dut (.*);

	frame_checker checker_i (.*);

	always #6 clk = ~clk;

	// Stall the result channel at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n && !(in_valid === 1'b1 && in_ready === 1'b1)
				&& !(out_valid === 1'b1 && out_ready === 1'b1)) begin
			quiet_cycles <= quiet_cycles + 1;
		end else begin
			quiet_cycles <= 0;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Random 32-bit word for payload fields that do not matter
	function automatic int rnd_word();
		return int'($urandom);
	endfunction

	// Offer one item after a random gap and hold it until accepted
	task automatic send_item(input logic [1:0] op, input int cx, input int cy,
			input int r, input int g, input int b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		coord_x <= cx[ppp_pkg::COORD_W-1:0];
		coord_y <= cy[ppp_pkg::COORD_W-1:0];
		red_in <= r[ppp_pkg::COLOR_W-1:0];
		green_in <= g[ppp_pkg::COLOR_W-1:0];
		blue_in <= b[ppp_pkg::COLOR_W-1:0];
		do @(posedge clk); while (in_ready !== 1'b1);
	endtask

	// Hold off the sender until every reply has come back
	task automatic drain_replies();
		in_valid <= 1'b0;
		@(posedge clk);
		while (replies_owed != 0) @(posedge clk);
	endtask

	// Bias coordinates toward a tiny patch so plots collide on the same pixels
	function automatic int pick_coord();
		int sel;
		sel = $urandom_range(99);
		if (sel < 40) return int'($urandom_range(6)) - 3;
		if (sel < 70) return int'($urandom_range(254)) - 127;
		if (sel < 82) begin
			case ($urandom_range(5))
				0: return 127;
				1: return -127;
				2: return 128;
				3: return -128;
				4: return 32767;
				default: return -32768;
			endcase
		end
		return int'($urandom_range(65535)) - 32768;
	endfunction

	task automatic send_random();
		int pick;
		int sel;
		int cx;
		int cy;
		int r;
		pick = $urandom_range(99);
		cx = pick_coord();
		cy = pick_coord();
		sel = $urandom_range(99);
		r = (sel < 10) ? 0 : (sel < 50) ? int'($urandom_range(16, 1))
			: int'($urandom_range(255));
		if (pick < 3) begin
			send_item(MODE_UNUSED, rnd_word(), rnd_word(), rnd_word(), rnd_word(),
				rnd_word());
		end else if (pick < 10) begin
			send_item(ppp_pkg::MODE_STATS, rnd_word(), rnd_word(), rnd_word(), rnd_word(),
				rnd_word());
		end else begin
			send_item(ppp_pkg::MODE_PLOT, cx, cy, r, int'($urandom_range(255)),
				int'($urandom_range(255)));
		end
	endtask

	initial begin
		int clear_at;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: priority rules, window edges, unused mode, clear
		send_item(ppp_pkg::MODE_STATS, 0, 0, 0, 0, 0);
		send_item(ppp_pkg::MODE_PLOT, 0, 0, 100, 1, 2);
		send_item(ppp_pkg::MODE_PLOT, 0, 0, 150, 3, 4);
		send_item(ppp_pkg::MODE_PLOT, 0, 0, 100, 5, 6);
		send_item(ppp_pkg::MODE_PLOT, 0, 0, 50, 7, 8);
		send_item(ppp_pkg::MODE_PLOT, 127, 127, 255, 255, 255);
		send_item(ppp_pkg::MODE_PLOT, -127, -127, 1, 0, 0);
		send_item(ppp_pkg::MODE_PLOT, 128, 0, 9, 9, 9);
		send_item(ppp_pkg::MODE_PLOT, 0, -128, 9, 9, 9);
		send_item(ppp_pkg::MODE_PLOT, -32768, 32767, 9, 9, 9);
		send_item(ppp_pkg::MODE_PLOT, 32767, -32768, 9, 9, 9);
		send_item(ppp_pkg::MODE_PLOT, 127, -127, 0, 170, 85);
		send_item(ppp_pkg::MODE_STATS, 0, 0, 0, 0, 0);
		send_item(ppp_pkg::MODE_PLOT, 0, 0, 0, 255, 0);
		send_item(MODE_UNUSED, -1, -1, 255, 255, 255);
		send_item(ppp_pkg::MODE_STATS, -1, -1, 255, 255, 255);
		send_item(ppp_pkg::MODE_CLEAR, 5, 5, 5, 5, 5);
		send_item(ppp_pkg::MODE_STATS, 0, 0, 0, 0, 0);
		send_item(ppp_pkg::MODE_PLOT, -127, 127, 255, 0, 255);
		send_item(ppp_pkg::MODE_STATS, 0, 0, 0, 0, 0);
		drain_replies();

		// Random phases: free flow, idle sender, stalled receiver, both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
				default: begin send_idle_pct = 24; recv_stall_pct = 24; end
			endcase
			clear_at = (phase % 2 == 0) ? int'($urandom_range(RANDOM_PER_PHASE - 1)) : -1;
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (n == clear_at) begin
					send_item(ppp_pkg::MODE_CLEAR, rnd_word(), rnd_word(), rnd_word(),
						rnd_word(), rnd_word());
				end else begin
					send_random();
				end
			end
			drain_replies();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && replies_owed == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/ppp_pkg.sv
hdl/ppp_ram.sv
hdl/priority_pixel_plotter.sv
sim/frame_checker.sv
sim/testbench.sv
